[rtl/lrs_pkg.sv]
// Shared types and constants for the Luby restart scale block.
// No dependencies; used by lrs_exp, lrs_mul and luby_restart_scale.
`default_nettype none

package lrs_pkg;

    // Field widths.
    localparam int IDX_W  = 31;
    localparam int SIZE_W = IDX_W + 1;
    localparam int SEQ_W  = 5;
    localparam int BASE_W = 16;
    localparam int ACC_W  = 64;
    localparam int HALF_W = ACC_W / 2;
    localparam int PROD_W = HALF_W + BASE_W;

    // Reset value of the base register (2.0 in Q4.12) and 1.0 in Q48.16.
    localparam logic [BASE_W-1:0] BASE_RESET = 16'd8192;
    localparam logic [ACC_W-1:0]  ACC_ONE    = 64'd65536;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_GROW,
        S_SHRINK,
        S_POW_LO,
        S_POW_HI,
        S_POW_ADD,
        S_DONE
    } t_state;

    // Commands to the exponent datapath.
    typedef enum logic [1:0] {
        EOP_NONE,
        EOP_LOAD,
        EOP_GROW,
        EOP_SHRINK
    } t_exp_op;

    // Commands to the power datapath.
    typedef enum logic [2:0] {
        MOP_NONE,
        MOP_INIT,
        MOP_LO,
        MOP_HI,
        MOP_ADD
    } t_mul_op;

    // Loop conditions reported by the exponent datapath.
    typedef struct packed {
        logic grow_more;
        logic shrink_more;
    } t_exp_sts;

endpackage

`default_nettype wire

[rtl/lrs_exp.sv]
// Exponent datapath: size, index and sequence registers with one grow/shrink step.
// Depends on lrs_pkg.
`default_nettype none

module lrs_exp (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  lrs_pkg::t_exp_op                  i_op,
    input  wire  [lrs_pkg::IDX_W-1:0]         i_index,
    output lrs_pkg::t_exp_sts                 o_sts,
    output logic [lrs_pkg::SEQ_W-1:0]         o_seq
);

    logic [lrs_pkg::IDX_W-1:0]  r_x;
    logic [lrs_pkg::IDX_W-1:0]  n_x;
    logic [lrs_pkg::SIZE_W-1:0] r_size;
    logic [lrs_pkg::SIZE_W-1:0] n_size;
    logic [lrs_pkg::SEQ_W-1:0]  r_seq;
    logic [lrs_pkg::SEQ_W-1:0]  n_seq;

    logic [lrs_pkg::SIZE_W-1:0] x_ext;
    logic [lrs_pkg::SIZE_W-1:0] size_m1;
    logic [lrs_pkg::SIZE_W-1:0] half;
    logic [lrs_pkg::SIZE_W-1:0] x_red;

    // Sizes are always of the form 2^k-1, so (size-1)>>1 is size>>1.
    assign x_ext   = {1'b0, r_x};
    assign size_m1 = r_size - lrs_pkg::SIZE_W'(1);
    assign half    = r_size >> 1;

    // The index never exceeds twice the new size, so the modulo needs at
    // most two subtractions of the new size, picked by comparison.
    always_comb begin
        if (x_ext >= size_m1) begin
            x_red = x_ext - size_m1;
        end else if (x_ext >= half) begin
            x_red = x_ext - half;
        end else begin
            x_red = x_ext;
        end
    end

    assign o_sts.grow_more   = (r_size <= x_ext);
    assign o_sts.shrink_more = (size_m1 != x_ext);
    assign o_seq             = r_seq;

    // Next values for the selected step.
    always_comb begin
        n_x    = r_x;
        n_size = r_size;
        n_seq  = r_seq;
        case (i_op)
            lrs_pkg::EOP_LOAD: begin
                n_x    = i_index;
                n_size = lrs_pkg::SIZE_W'(1);
                n_seq  = '0;
            end
            lrs_pkg::EOP_GROW: begin
                n_size = {r_size[lrs_pkg::SIZE_W-2:0], 1'b1};
                n_seq  = r_seq + lrs_pkg::SEQ_W'(1);
            end
            lrs_pkg::EOP_SHRINK: begin
                n_size = half;
                n_seq  = r_seq - lrs_pkg::SEQ_W'(1);
                n_x    = x_red[lrs_pkg::IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Datapath registers; reset leaves them as after a load of index zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= '0;
            r_size <= lrs_pkg::SIZE_W'(1);
            r_seq  <= '0;
        end else begin
            r_x    <= n_x;
            r_size <= n_size;
            r_seq  <= n_seq;
        end
    end

endmodule

`default_nettype wire

[rtl/lrs_mul.sv]
// Power datapath: one shared 32x16 multiplier builds the Q48.16 power with saturation.
// Depends on lrs_pkg.
`default_nettype none

module lrs_mul (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  lrs_pkg::t_mul_op                  i_op,
    input  wire  [lrs_pkg::BASE_W-1:0]        i_base,
    output logic [lrs_pkg::ACC_W-1:0]         o_acc,
    output logic                              o_sat
);

    logic [lrs_pkg::ACC_W-1:0]  r_acc;
    logic [lrs_pkg::ACC_W-1:0]  n_acc;
    logic                       r_sat;
    logic                       n_sat;
    logic [lrs_pkg::PROD_W-1:0] r_prod;
    logic [lrs_pkg::PROD_W-1:0] n_prod;
    logic [lrs_pkg::PROD_W-1:0] r_plo;
    logic [lrs_pkg::PROD_W-1:0] n_plo;

    logic [lrs_pkg::HALF_W-1:0] mul_a;
    logic [lrs_pkg::PROD_W-1:0] mul_p;
    logic [lrs_pkg::ACC_W:0]    sum;

    // Shared multiplier: low half of the accumulator first, then the high half.
    assign mul_a = (i_op == lrs_pkg::MOP_HI) ? r_acc[lrs_pkg::ACC_W-1:lrs_pkg::HALF_W]
                                             : r_acc[lrs_pkg::HALF_W-1:0];
    assign mul_p = {{lrs_pkg::BASE_W{1'b0}}, mul_a}
                 * {{lrs_pkg::HALF_W{1'b0}}, i_base};

    // Recombine: (p_hi << 20) + (p_lo >> 12), with a carry out meaning overflow.
    assign sum = {1'b0, r_prod[43:0], 20'b0}
               + {29'b0, r_plo[lrs_pkg::PROD_W-1:12]};

    assign o_acc = r_acc;
    assign o_sat = r_sat;

    always_comb begin
        n_acc  = r_acc;
        n_sat  = r_sat;
        n_prod = r_prod;
        n_plo  = r_plo;
        case (i_op)
            lrs_pkg::MOP_INIT: begin
                n_acc = lrs_pkg::ACC_ONE;
                n_sat = 1'b0;
            end
            lrs_pkg::MOP_LO: begin
                n_prod = mul_p;
            end
            lrs_pkg::MOP_HI: begin
                n_plo  = r_prod;
                n_prod = mul_p;
            end
            lrs_pkg::MOP_ADD: begin
                if ((|r_prod[lrs_pkg::PROD_W-1:44]) || sum[lrs_pkg::ACC_W]) begin
                    n_acc = '1;
                    n_sat = 1'b1;
                end else begin
                    n_acc = sum[lrs_pkg::ACC_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // Accumulator and partial products; the flag is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else begin
            r_sat <= n_sat;
        end
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_plo  <= n_plo;
    end

endmodule

`default_nettype wire

[rtl/luby_restart_scale.sv]
// Top level of the Luby restart scale block: sequencer, base register, output register.
// Depends on lrs_pkg, lrs_exp and lrs_mul.
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+--------------------------------------
//  in       | input     | i_in_valid / o_in_stall | i_restart_index
//  out      | output    | o_out_valid/i_out_stall | o_scale_value, o_exponent, o_saturated
//  cfg      | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (restart_base)
//
// A transaction takes a load step, the grow steps and the shrink steps (each up to 31)
// and an exit step after each loop, then per multiply of the shared 32x16 multiplier
// (seq multiplies, fewer after saturation) a low, a high and an add step, an exit step
// from that loop, and a finish step.
// Reset (synchronous, active low) returns to idle, empties the output register and
// sets the base to 2.0. A finished result waits in the output register, so the next
// input transaction can start while the result is stalled.
`default_nettype none

module luby_restart_scale (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire  [lrs_pkg::IDX_W-1:0]         i_restart_index,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic [lrs_pkg::ACC_W-1:0]         o_scale_value,
    output logic [lrs_pkg::SEQ_W-1:0]         o_exponent,
    output logic                              o_saturated,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [lrs_pkg::BASE_W-1:0]        i_cfg_data
);

    lrs_pkg::t_state            r_state;
    lrs_pkg::t_state            n_state;
    logic [lrs_pkg::SEQ_W-1:0]  r_cnt;
    logic [lrs_pkg::SEQ_W-1:0]  n_cnt;
    logic [lrs_pkg::BASE_W-1:0] r_base;
    logic                       r_out_valid;
    logic [lrs_pkg::ACC_W-1:0]  r_out_value;
    logic [lrs_pkg::SEQ_W-1:0]  r_out_exp;
    logic                       r_out_sat;

    lrs_pkg::t_exp_op           exp_op;
    lrs_pkg::t_exp_sts          exp_sts;
    logic [lrs_pkg::SEQ_W-1:0]  exp_seq;
    lrs_pkg::t_mul_op           mul_op;
    logic [lrs_pkg::ACC_W-1:0]  mul_acc;
    logic                       mul_sat;

    logic                       in_take;
    logic                       out_free;
    logic                       out_load;
    logic                       pow_end;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign pow_end  = (r_cnt == '0) || mul_sat;

    lrs_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (exp_op),
        .i_index (i_restart_index),
        .o_sts   (exp_sts),
        .o_seq   (exp_seq)
    );

    lrs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mul_op),
        .i_base  (r_base),
        .o_acc   (mul_acc),
        .o_sat   (mul_sat)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lrs_pkg::S_IDLE: begin
                if (in_take) n_state = lrs_pkg::S_GROW;
            end
            lrs_pkg::S_GROW: begin
                if (!exp_sts.grow_more) n_state = lrs_pkg::S_SHRINK;
            end
            lrs_pkg::S_SHRINK: begin
                if (!exp_sts.shrink_more) n_state = lrs_pkg::S_POW_LO;
            end
            lrs_pkg::S_POW_LO: begin
                n_state = pow_end ? lrs_pkg::S_DONE : lrs_pkg::S_POW_HI;
            end
            lrs_pkg::S_POW_HI: begin
                n_state = lrs_pkg::S_POW_ADD;
            end
            lrs_pkg::S_POW_ADD: begin
                n_state = lrs_pkg::S_POW_LO;
            end
            lrs_pkg::S_DONE: begin
                if (out_free) n_state = lrs_pkg::S_IDLE;
            end
            default: begin
                n_state = lrs_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: datapath commands, loop counter and result load.
    always_comb begin
        exp_op     = lrs_pkg::EOP_NONE;
        mul_op     = lrs_pkg::MOP_NONE;
        n_cnt      = r_cnt;
        out_load   = 1'b0;
        o_in_stall = 1'b1;
        unique case (r_state)
            lrs_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (in_take) exp_op = lrs_pkg::EOP_LOAD;
            end
            lrs_pkg::S_GROW: begin
                if (exp_sts.grow_more) exp_op = lrs_pkg::EOP_GROW;
            end
            lrs_pkg::S_SHRINK: begin
                if (exp_sts.shrink_more) begin
                    exp_op = lrs_pkg::EOP_SHRINK;
                end else begin
                    mul_op = lrs_pkg::MOP_INIT;
                    n_cnt  = exp_seq;
                end
            end
            lrs_pkg::S_POW_LO: begin
                if (!pow_end) mul_op = lrs_pkg::MOP_LO;
            end
            lrs_pkg::S_POW_HI: begin
                mul_op = lrs_pkg::MOP_HI;
            end
            lrs_pkg::S_POW_ADD: begin
                mul_op = lrs_pkg::MOP_ADD;
                n_cnt  = r_cnt - lrs_pkg::SEQ_W'(1);
            end
            lrs_pkg::S_DONE: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    // Sequencer state and loop counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt;
    end

    // Base register; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= lrs_pkg::BASE_RESET;
        end else if (i_cfg_valid) begin
            r_base <= i_cfg_data;
        end
    end

    // Output register: loading has priority over the downstream transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_value <= mul_acc;
            r_out_exp   <= exp_seq;
            r_out_sat   <= mul_sat;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_scale_value = r_out_value;
    assign o_exponent    = r_out_exp;
    assign o_saturated   = r_out_sat;

endmodule

`default_nettype wire
